// File: hw/rtl/huffman_code_bit_packer_core_defines.svh
// ----------------------------------------------------------------------------
// Huffman code bit packer: assertion macros
// Shared concurrent assertion forms for the packer core.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_DEFINES_SVH

// same-cycle implication
`define HCBP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcbp assertion failed");

// next-cycle implication
`define HCBP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcbp assertion failed");

`endif

// File: hw/rtl/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer package
// Widths, request codes, table entry layout and inter-module structs.
// ----------------------------------------------------------------------------
package hcbp_pkg;

   localparam int unsigned TABLE_DEPTH  = 256;
   localparam int unsigned ADDR_W       = $clog2(TABLE_DEPTH);
   localparam int unsigned CODE_W       = 16;
   localparam int unsigned LEN_W        = 5;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned CNT_W        = $clog2(BYTE_W);
   localparam int unsigned MAX_CODE_LEN = 16;
   localparam int unsigned CODE_LIMIT   = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   // pending bits plus a full code
   localparam int unsigned COMB_W       = BYTE_W + CODE_W;

   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_ENCODE = 2'd1,
      REQ_FLUSH  = 2'd2
   } req_kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } ctrl_state_type;

   typedef struct packed {
      logic [CODE_W-1:0] bits;
      logic [LEN_W-1:0]  len;
   } code_entry_type;

   typedef struct packed {
      logic encode;   // table data valid this cycle, pack it
      logic flush;    // emit partial word with last
   } pack_cmd_type;

   typedef struct packed {
      logic [1:0]        count;
      logic [BYTE_W-1:0] first_word;
      logic [BYTE_W-1:0] second_word;
      logic              last;
   } pack_result_type;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
      clamp_len = (len > LEN_W'(CODE_LIMIT)) ? LEN_W'(CODE_LIMIT) : len;
   endfunction

endpackage

// File: hw/rtl/hcbp_channels.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer channels
// Valid/ready request and response interfaces.
// ----------------------------------------------------------------------------
interface hcbp_req_if
   import hcbp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic [BYTE_W-1:0] symbol;
   logic [CODE_W-1:0] code_bits;
   logic [LEN_W-1:0]  code_len;

   modport source (output valid, req_type, symbol, code_bits, code_len, input ready);
   modport sink   (input valid, req_type, symbol, code_bits, code_len, output ready);
endinterface

interface hcbp_rsp_if
   import hcbp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;

   modport source (output valid, out_byte, last, input ready);
   modport sink   (input valid, out_byte, last, output ready);
endinterface

// File: hw/rtl/huffman_code_bit_packer_core.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer core
// Code table lookup and bit packing into bytes, valid/ready in and out.
// ----------------------------------------------------------------------------
// Works one request word at a time. A load writes the 256-entry code table in
// the cycle it is accepted (lengths above 16 are clamped to 16). An encode
// reads the registered-read table and packs the code in the following cycle,
// then drains its output words (0 to 2). A flush is packed in the cycle it is
// accepted and drains one word, which has last set and is zero padded on the
// right (a zero word when no bits are pending). The next request is taken once
// the two-entry output queue has drained. Reading a table entry that was never
// loaded gives an undefined code. No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "huffman_code_bit_packer_core_defines.svh"

module huffman_code_bit_packer_core
   import hcbp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   hcbp_req_if.sink  req_chan,
   hcbp_rsp_if.source rsp_chan
);

   ctrl_state_type  state_ff, state_in;
   req_kind_type    req_kind;
   logic            req_fire;
   logic            q_empty;
   logic            ram_wr_en;
   logic            ram_rd_en;
   code_entry_type  ram_wr_data;
   code_entry_type  ram_rd_data;
   pack_cmd_type    pack_cmd;
   pack_result_type pack_res;

   assign req_kind = req_kind_type'(req_chan.req_type);
   assign req_fire = req_chan.valid && req_chan.ready;

   // control: take a request only when idle and nothing is left to send
   always_comb begin
      state_in        = state_ff;
      req_chan.ready  = 1'b0;
      ram_wr_en       = 1'b0;
      ram_rd_en       = 1'b0;
      pack_cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = q_empty;
            if (req_chan.valid && q_empty) begin
               case (req_kind)
                  REQ_LOAD: begin
                     ram_wr_en = 1'b1;
                  end
                  REQ_ENCODE: begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_LOOKUP;
                  end
                  REQ_FLUSH: begin
                     pack_cmd.flush = 1'b1;
                  end
                  default: begin
                     // unknown request code: dropped
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            // table data now registered at the RAM output
            pack_cmd.encode = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign ram_wr_data.bits = req_chan.code_bits;
   assign ram_wr_data.len  = clamp_len(req_chan.code_len);

   hcbp_code_ram u_code_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_chan.symbol),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (req_chan.symbol),
      .rd_data (ram_rd_data)
   );

   hcbp_bit_packer u_bit_packer (
      .clock  (clock),
      .reset  (reset),
      .cmd    (pack_cmd),
      .entry  (ram_rd_data),
      .result (pack_res)
   );

   hcbp_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .result     (pack_res),
      .pop        (rsp_chan.valid && rsp_chan.ready),
      .head_valid (rsp_chan.valid),
      .head_word  (rsp_chan.out_byte),
      .head_last  (rsp_chan.last),
      .empty      (q_empty)
   );

   // encode always goes through the table read cycle
   `HCBP_ASSERT_NXT(a_encode_lookup, clock, reset, req_fire && req_kind == REQ_ENCODE, state_ff == ST_LOOKUP)
   // flush word is presented right after the request
   `HCBP_ASSERT_NXT(a_flush_last, clock, reset, req_fire && req_kind == REQ_FLUSH, rsp_chan.valid && rsp_chan.last)
   // words only enter an empty queue
   `HCBP_ASSERT_IMP(a_push_empty, clock, reset, pack_res.count != 2'd0, q_empty)
   // a pending word blocks new requests
   `HCBP_ASSERT_IMP(a_busy_blocks, clock, reset, !q_empty || state_ff == ST_LOOKUP, !req_chan.ready)

endmodule

// File: hw/rtl/hcbp_code_ram.sv
// ----------------------------------------------------------------------------
// Huffman code table RAM
// 256 x 21 single-port-write, registered-read code table.
// ----------------------------------------------------------------------------
module hcbp_code_ram
   import hcbp_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  code_entry_type    wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output code_entry_type    rd_data
);

   code_entry_type table_mem [TABLE_DEPTH];
   code_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/hcbp_bit_packer.sv
// ----------------------------------------------------------------------------
// Huffman bit packer datapath
// Appends a code to the pending bits and splits out full words, or flushes them.
// ----------------------------------------------------------------------------
module hcbp_bit_packer
   import hcbp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  pack_cmd_type    cmd,
   input  code_entry_type  entry,
   output pack_result_type result
);

   logic [BYTE_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic [CODE_W:0]     code_mask;
   logic [CODE_W-1:0]   code_masked;
   logic [COMB_W-1:0]   combined;
   logic [LEN_W-1:0]    total;
   logic [BYTE_W-1:0]   rem_mask;
   logic [2*BYTE_W-1:0] flush_wide;

   always_comb begin
      code_mask   = ((CODE_W+1)'(1) << entry.len) - (CODE_W+1)'(1);
      code_masked = entry.bits & code_mask[CODE_W-1:0];
      combined    = (COMB_W'(acc_ff) << entry.len) | COMB_W'(code_masked);
      total       = LEN_W'(cnt_ff) + entry.len;
      rem_mask    = (BYTE_W'(1) << total[CNT_W-1:0]) - BYTE_W'(1);
      // left-align pending bits, zero pad below
      flush_wide  = {acc_ff, BYTE_W'(0)} >> cnt_ff;

      acc_in = acc_ff;
      cnt_in = cnt_ff;
      result = '0;

      if (cmd.encode) begin
         result.count       = total[LEN_W-1:CNT_W];
         result.first_word  = BYTE_W'(combined >> (total - LEN_W'(BYTE_W)));
         result.second_word = BYTE_W'(combined >> (total - LEN_W'(2*BYTE_W)));
         acc_in             = combined[BYTE_W-1:0] & rem_mask;
         cnt_in             = total[CNT_W-1:0];
      end else if (cmd.flush) begin
         result.count      = 2'd1;
         result.first_word = flush_wide[BYTE_W-1:0];
         result.last       = 1'b1;
         acc_in            = '0;
         cnt_in            = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: hw/rtl/hcbp_out_queue.sv
// ----------------------------------------------------------------------------
// Huffman packer output queue
// Two-slot holding queue for the words of one request.
// ----------------------------------------------------------------------------
module hcbp_out_queue
   import hcbp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  pack_result_type   result,
   input  logic              pop,
   output logic              head_valid,
   output logic [BYTE_W-1:0] head_word,
   output logic              head_last,
   output logic              empty
);

   logic [1:0]        count_ff, count_in;
   logic [BYTE_W-1:0] slot0_word_ff, slot0_word_in;
   logic              slot0_last_ff, slot0_last_in;
   logic [BYTE_W-1:0] slot1_word_ff, slot1_word_in;

   // pushes only land in an empty queue, so push and pop never overlap
   always_comb begin
      count_in      = count_ff;
      slot0_word_in = slot0_word_ff;
      slot0_last_in = slot0_last_ff;
      slot1_word_in = slot1_word_ff;
      if (result.count != 2'd0) begin
         count_in      = result.count;
         slot0_word_in = result.first_word;
         slot0_last_in = result.last;
         slot1_word_in = result.second_word;
      end else if (pop) begin
         count_in      = count_ff - 2'd1;
         slot0_word_in = slot1_word_ff;
         slot0_last_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_word_ff <= slot0_word_in;
      slot0_last_ff <= slot0_last_in;
      slot1_word_ff <= slot1_word_in;
   end

   assign head_valid = (count_ff != 2'd0);
   assign head_word  = slot0_word_ff;
   assign head_last  = slot0_last_ff;
   assign empty      = (count_ff == 2'd0);

endmodule

// File: sim/huffman_code_bit_packer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code bit packer core testbench
// Loads the code table, encodes and flushes words with and without random idling
// on both channels, and checks every packed word against a local bit model.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_core_tb;
   import hcbp_pkg::*;

   // request code that the core must ignore
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   // generous watchdog bound on the whole run
   localparam int unsigned RUN_LIMIT = 400_000;
   // cycles to let the core settle after the last expected word
   localparam int unsigned SETTLE_CYCLES = 12;

   typedef struct {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
   } packed_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hcbp_req_if req_chan ();
   hcbp_rsp_if rsp_chan ();

   huffman_code_bit_packer_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Packing model: own copy of the code table and the bit accumulator
   // ------------------------------------------------------------------------
   logic [CODE_W-1:0] code_bits_tbl [TABLE_DEPTH];
   logic [LEN_W-1:0]  code_len_tbl  [TABLE_DEPTH];
   logic [BYTE_W-1:0] acc_bits = '0;
   int unsigned       acc_fill = 0;
   packed_word_type   words_due[$];

   // bookkeeping for the summary
   int unsigned requests_sent = 0;
   int unsigned words_checked = 0;
   int unsigned flush_words   = 0;
   int unsigned mismatches    = 0;
   int unsigned cycle_count   = 0;

   // idling switches for each side
   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;

   // Work out the words a request yields and append them to words_due.
   function automatic void predict_packed_words(input logic [1:0] kind,
                                                input logic [BYTE_W-1:0] sym,
                                                input logic [CODE_W-1:0] bits,
                                                input logic [LEN_W-1:0] len);
      packed_word_type word;
      logic [CODE_W-1:0] code;
      int unsigned clen;
      case (kind)
         REQ_LOAD: begin
            code_bits_tbl[sym] = bits;
            // lengths past the limit are cut back to the limit
            code_len_tbl[sym] = (len > LEN_W'(CODE_LIMIT)) ? LEN_W'(CODE_LIMIT) : len;
         end
         REQ_ENCODE: begin
            code = code_bits_tbl[sym];
            clen = code_len_tbl[sym];
            // root bit first: walk from bit clen-1 down to bit 0
            for (int i = clen; i > 0; i--) begin
               acc_bits = {acc_bits[BYTE_W-2:0], code[i-1]};
               acc_fill++;
               if (acc_fill == BYTE_W) begin
                  word.out_byte = acc_bits;
                  word.last     = 1'b0;
                  words_due = {words_due, word};
                  acc_bits = '0;
                  acc_fill = 0;
               end
            end
         end
         REQ_FLUSH: begin
            // zero pad on the right; an empty accumulator gives a zero word
            word.out_byte = (acc_fill == 0) ? '0 : BYTE_W'(acc_bits << (BYTE_W - acc_fill));
            word.last     = 1'b1;
            words_due = {words_due, word};
            acc_bits = '0;
            acc_fill = 0;
         end
         default: ; // unused code: no word, no state change
      endcase
   endfunction

   function automatic int unsigned pick_gap(input bit idle_on);
      return idle_on ? $urandom_range(0, 10) : 0;
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   // Waits its drawn gap, presents the word and holds it until accepted.
   // valid is lowered only when a gap follows, so back-to-back words keep it
   // high without a second assignment in the same step.
   task automatic send_word(input logic [1:0] kind, input logic [BYTE_W-1:0] sym,
                            input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
      int unsigned gap;
      gap = pick_gap(send_idle_on);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.req_type  <= kind;
      req_chan.symbol    <= sym;
      req_chan.code_bits <= bits;
      req_chan.code_len  <= len;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      predict_packed_words(kind, sym, bits, len);
      requests_sent++;
   endtask

   // Drop valid and hold off until every expected word is out, plus settle.
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly short lengths, some zero, some past the limit (up to 31, the
   // largest value the 5-bit field holds).
   function automatic logic [LEN_W-1:0] pick_code_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return LEN_W'($urandom_range(17, 31));
      if (roll < 14) return '0;
      return LEN_W'($urandom_range(1, 16));
   endfunction

   task automatic send_random_load(input logic [BYTE_W-1:0] sym);
      send_word(REQ_LOAD, sym, CODE_W'($urandom_range(0, 65535)), pick_code_len());
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stalls, one check per accepted word
   // ------------------------------------------------------------------------
   initial begin : rsp_side
      int unsigned stall;
      packed_word_type want;
      rsp_chan.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = pick_gap(recv_idle_on);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         if (words_due.size() == 0) begin
            $error("unexpected word: out_byte 8'h%02h, last %0b",
                   rsp_chan.out_byte, rsp_chan.last);
            mismatches++;
         end else begin
            want = words_due.pop_front();
            if (rsp_chan.out_byte !== want.out_byte) begin
               $error("out_byte: expected 8'h%02h, actual 8'h%02h",
                      want.out_byte, rsp_chan.out_byte);
               mismatches++;
            end
            if (rsp_chan.last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_chan.last);
               mismatches++;
            end
            if (want.last) flush_words++;
         end
         words_checked++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Hand-picked loads and requests: zero length, full 16-bit code, lengths
   // past the limit, bits above the length, empty flush, unused request
   // code, and a code that straddles two words.
   task automatic test_directed_cases();
      send_word(REQ_LOAD, 8'h00, 16'hFFFF, 5'd0);    // zero length
      send_word(REQ_LOAD, 8'hFF, 16'hFFFF, 5'd16);   // longest legal code
      send_word(REQ_LOAD, 8'h80, 16'hC3A5, 5'd31);   // way past the limit
      send_word(REQ_LOAD, 8'h7F, 16'h1234, 5'd17);   // just past the limit
      send_word(REQ_LOAD, 8'h01, 16'hFFFE, 5'd1);    // upper bits ignored
      send_word(REQ_LOAD, 8'h55, 16'h00A5, 5'd8);
      send_word(REQ_LOAD, 8'h2A, 16'h0005, 5'd3);
      send_word(REQ_FLUSH, 8'h00, 16'h0000, 5'd0);   // empty flush
      send_word(REQ_ENCODE, 8'h00, 16'h0000, 5'd0);  // emits nothing
      send_word(REQ_ENCODE, 8'hFF, 16'h0000, 5'd0);  // two full words
      send_word(REQ_UNUSED, 8'hFF, 16'hFFFF, 5'd31); // ignored
      send_word(REQ_ENCODE, 8'h01, 16'h0000, 5'd0);
      send_word(REQ_ENCODE, 8'h80, 16'h0000, 5'd0);  // 1 + 16 bits: two words
      send_word(REQ_FLUSH, 8'hFF, 16'hFFFF, 5'd31);  // one pending bit
      send_word(REQ_ENCODE, 8'h2A, 16'h0000, 5'd0);
      send_word(REQ_ENCODE, 8'h2A, 16'h0000, 5'd0);
      send_word(REQ_ENCODE, 8'h2A, 16'h0000, 5'd0);  // 9 bits: one word
      send_word(REQ_ENCODE, 8'h55, 16'h0000, 5'd0);  // straddles
      send_word(REQ_FLUSH, 8'h00, 16'h0000, 5'd0);
      send_word(REQ_ENCODE, 8'h7F, 16'h0000, 5'd0);
      send_word(REQ_ENCODE, 8'h00, 16'h0000, 5'd0);
      send_word(REQ_FLUSH, 8'h00, 16'h0000, 5'd0);
   endtask

   // Every entry gets a code so that random encodes never hit an empty slot.
   task automatic test_table_fill();
      for (int s = 0; s < TABLE_DEPTH; s++)
         send_random_load(BYTE_W'(s));
   endtask

   // Messages: a run of encodes with the odd reload or unused code mixed in,
   // closed by a flush most of the time.
   task automatic test_message_traffic(input int unsigned n_items);
      int unsigned sent;
      int unsigned run_len;
      int unsigned roll;
      sent = 0;
      while (sent < n_items) begin
         run_len = $urandom_range(0, 12);
         for (int k = 0; k < run_len; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
               send_random_load(BYTE_W'($urandom_range(0, 255)));
            else if (roll < 10)
               send_word(REQ_UNUSED, BYTE_W'($urandom_range(0, 255)),
                         CODE_W'($urandom_range(0, 65535)), LEN_W'($urandom_range(0, 31)));
            else
               send_word(REQ_ENCODE, BYTE_W'($urandom_range(0, 255)),
                         CODE_W'($urandom_range(0, 65535)), LEN_W'($urandom_range(0, 31)));
         end
         if ($urandom_range(0, 9) != 0)
            send_word(REQ_FLUSH, BYTE_W'($urandom_range(0, 255)),
                      CODE_W'($urandom_range(0, 65535)), LEN_W'($urandom_range(0, 31)));
         sent += run_len + 1;
      end
   endtask

   task automatic test_random_idling(input int unsigned n_items);
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      test_message_traffic(n_items);
   endtask

   // Sender stops until the core has delivered everything, then resumes.
   task automatic test_drain_pause();
      wait_for_drain();
      test_message_traffic(40);
   endtask

   task automatic test_back_to_back(input int unsigned n_items);
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      test_message_traffic(n_items);
   endtask

   // Sender flat out against a stalling sink.
   task automatic test_backpressure(input int unsigned n_items);
      send_idle_on = 1'b0;
      recv_idle_on = 1'b1;
      test_message_traffic(n_items);
   endtask

   // Slow sender against a sink that is always ready.
   task automatic test_starved_sink(input int unsigned n_items);
      send_idle_on = 1'b1;
      recv_idle_on = 1'b0;
      test_message_traffic(n_items);
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      req_chan.valid     = 1'b0;
      req_chan.req_type  = REQ_LOAD;
      req_chan.symbol    = '0;
      req_chan.code_bits = '0;
      req_chan.code_len  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_table_fill();
      test_random_idling(400);
      test_drain_pause();
      test_back_to_back(150);
      test_backpressure(150);
      test_starved_sink(100);
      test_random_idling(60);

      wait_for_drain();
      $display("Covered %0d requests: table fill, encode/flush messages, reloads, unused codes",
               requests_sent);
      $display("Checked %0d packed words (%0d closing words) under idling and back-to-back",
               words_checked, flush_words);
      if (mismatches == 0 && words_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/hcbp_pkg.sv
hw/rtl/hcbp_channels.sv
hw/rtl/hcbp_code_ram.sv
hw/rtl/hcbp_bit_packer.sv
hw/rtl/hcbp_out_queue.sv
hw/rtl/huffman_code_bit_packer_core.sv
sim/huffman_code_bit_packer_core_tb.sv
